### rtl/core/sdofp_pkg.sv
// ----------------------------------------------------------------------------
// sdofp_pkg
// Shared widths, codes and transaction types of the oscillator peak block.
// ----------------------------------------------------------------------------
package sdofp_pkg;

   // fixed-point formats
   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 30;
   localparam int STATE_BITS     = 48;
   localparam int COEF_BITS      = 32;
   localparam int PEAK_BITS      = STATE_BITS - 1;

   // state operands are split in two halves for the multipliers
   localparam int LO_BITS      = STATE_BITS / 2;
   localparam int HI_BITS      = STATE_BITS - LO_BITS;
   localparam int LO_PROD_BITS = COEF_BITS + LO_BITS + 1;
   localparam int HI_PROD_BITS = COEF_BITS + HI_BITS;
   localparam int F_PROD_BITS  = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS     = COEF_BITS + STATE_BITS + 3;
   localparam int RND_BITS     = ACC_BITS - COEF_FRAC_BITS;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((PEAK_BITS + 7) / 8) * 8;

   // register file
   localparam int NUM_COEFS     = 8;
   localparam int CSR_IDX_BITS  = $clog2(NUM_COEFS);
   localparam int CSR_ADDR_BITS = CSR_IDX_BITS + 2;
   localparam int CSR_DATA_BITS = 32;

   // front to back queue, depth a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_DISP_FROM_DISP       = 3'd0,
      REG_DISP_FROM_VEL        = 3'd1,
      REG_DISP_FROM_PREV_FORCE = 3'd2,
      REG_DISP_FROM_NEW_FORCE  = 3'd3,
      REG_VEL_FROM_DISP        = 3'd4,
      REG_VEL_FROM_VEL         = 3'd5,
      REG_VEL_FROM_PREV_FORCE  = 3'd6,
      REG_VEL_FROM_NEW_FORCE   = 3'd7
   } coef_index_type;

   typedef struct packed {
      logic [COEF_BITS-1:0] disp_from_disp;
      logic [COEF_BITS-1:0] disp_from_vel;
      logic [COEF_BITS-1:0] disp_from_prev_force;
      logic [COEF_BITS-1:0] disp_from_new_force;
      logic [COEF_BITS-1:0] vel_from_disp;
      logic [COEF_BITS-1:0] vel_from_vel;
      logic [COEF_BITS-1:0] vel_from_prev_force;
      logic [COEF_BITS-1:0] vel_from_new_force;
   } coef_set_type;

   // first sample of a record only primes, the rest update the oscillator
   typedef enum logic {
      KIND_PRIME  = 1'b0,
      KIND_UPDATE = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type          kind;
      logic                   last;
      logic [SAMPLE_BITS-1:0] sample;
   } item_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic                 overflowed;
      logic [PEAK_BITS-1:0] peak;
   } result_type;

   typedef enum logic [1:0] {
      ENG_IDLE = 2'd0,
      ENG_SUM  = 2'd1,
      ENG_SAT  = 2'd2,
      ENG_FIN  = 2'd3
   } engine_state_type;

endpackage

### rtl/core/sdof_response_spectrum_peak.sv
// An updating sample passes multiply, sum and round, and saturate; the record's result
// is registered once the result register is free. A new updating sample waits for the
// last to saturate (the displacement/velocity feedback loop through the multipliers);
// priming samples go one per cycle when idle, a record's last only with the result
// register free. A 4-entry queue takes input transactions back to back until full.
// Reset (synchronous) clears coefficients, oscillator state, queue and result.
// ----------------------------------------------------------------------------
// sdof_response_spectrum_peak
// Peak displacement of a damped single-degree-of-freedom oscillator driven
// by a sampled excitation record, one result per record.
// ----------------------------------------------------------------------------
module sdof_response_spectrum_peak
   import sdofp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // sample transactions
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [23:0] sample
   input  logic                     req_tlast,   // last_sample
   // result transactions
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [46:0] peak_displacement, [47] zero
   output logic                     rsp_tuser,   // [0] overflowed
   // coefficient registers
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   coef_set_type     coefs;
   queue_status_type qstat;
   item_type         push_item;
   item_type         head;
   result_type       out_result;
   logic             push;
   logic             pop;

   sdofp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coefs       (coefs)
   );

   sdofp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .qstat      (qstat),
      .push       (push),
      .push_item  (push_item)
   );

   sdofp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   sdofp_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .coefs      (coefs),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   // result packing
   assign rsp_tdata = {{(RSP_DATA_BITS-PEAK_BITS){1'b0}}, out_result.peak};
   assign rsp_tuser = out_result.overflowed;

endmodule

### rtl/core/sdofp_csr.sv
// ----------------------------------------------------------------------------
// sdofp_csr
// APB-style coefficient register file with read-back.
// ----------------------------------------------------------------------------
module sdofp_csr
   import sdofp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output coef_set_type             coefs
);

   coef_set_type   coefs_ff;
   coef_index_type index;
   logic           wr_en;

   assign csr_pready = 1'b1;
   assign index      = coef_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign coefs      = coefs_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= '0;
      end else if (wr_en) begin
         unique case (index)
            REG_DISP_FROM_DISP:       coefs_ff.disp_from_disp       <= csr_pwdata;
            REG_DISP_FROM_VEL:        coefs_ff.disp_from_vel        <= csr_pwdata;
            REG_DISP_FROM_PREV_FORCE: coefs_ff.disp_from_prev_force <= csr_pwdata;
            REG_DISP_FROM_NEW_FORCE:  coefs_ff.disp_from_new_force  <= csr_pwdata;
            REG_VEL_FROM_DISP:        coefs_ff.vel_from_disp        <= csr_pwdata;
            REG_VEL_FROM_VEL:         coefs_ff.vel_from_vel         <= csr_pwdata;
            REG_VEL_FROM_PREV_FORCE:  coefs_ff.vel_from_prev_force  <= csr_pwdata;
            REG_VEL_FROM_NEW_FORCE:   coefs_ff.vel_from_new_force   <= csr_pwdata;
         endcase
      end
   end

   // read-back mux
   always_comb begin
      unique case (index)
         REG_DISP_FROM_DISP:       csr_prdata = coefs_ff.disp_from_disp;
         REG_DISP_FROM_VEL:        csr_prdata = coefs_ff.disp_from_vel;
         REG_DISP_FROM_PREV_FORCE: csr_prdata = coefs_ff.disp_from_prev_force;
         REG_DISP_FROM_NEW_FORCE:  csr_prdata = coefs_ff.disp_from_new_force;
         REG_VEL_FROM_DISP:        csr_prdata = coefs_ff.vel_from_disp;
         REG_VEL_FROM_VEL:         csr_prdata = coefs_ff.vel_from_vel;
         REG_VEL_FROM_PREV_FORCE:  csr_prdata = coefs_ff.vel_from_prev_force;
         REG_VEL_FROM_NEW_FORCE:   csr_prdata = coefs_ff.vel_from_new_force;
      endcase
   end

endmodule

### rtl/core/sdofp_front.sv
// ----------------------------------------------------------------------------
// sdofp_front
// Accepts sample transactions and tags each as priming or updating.
// ----------------------------------------------------------------------------
module sdofp_front
   import sdofp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tlast,
   input  queue_status_type         qstat,
   output logic                     push,
   output item_type                 push_item
);

   logic primed_ff;
   logic primed_in;

   assign req_tready = !qstat.full;
   assign push       = req_tvalid && !qstat.full;

   // classification by position in the record
   assign push_item.kind   = primed_ff ? KIND_UPDATE : KIND_PRIME;
   assign push_item.last   = req_tlast;
   assign push_item.sample = req_tdata[SAMPLE_BITS-1:0];

   // a record ends on its last sample, the next one primes again
   assign primed_in = push ? !req_tlast : primed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
      end else begin
         primed_ff <= primed_in;
      end
   end

endmodule

### rtl/core/sdofp_queue.sv
// ----------------------------------------------------------------------------
// sdofp_queue
// Short first-in first-out queue between the front and the engine.
// ----------------------------------------------------------------------------
module sdofp_queue
   import sdofp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head,
   output queue_status_type qstat
);

   item_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QCNT_BITS-1:0] count_in;

   assign head            = entry_ff[rd_ptr_ff];
   assign qstat.not_empty = count_ff != '0;
   assign qstat.full      = count_ff == QCNT_BITS'(QUEUE_DEPTH);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/sdofp_engine.sv
// ----------------------------------------------------------------------------
// sdofp_engine
// Oscillator recurrence: multiply, sum and round, saturate, peak tracking.
// ----------------------------------------------------------------------------
module sdofp_engine
   import sdofp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  coef_set_type     coefs,
   input  item_type         head,
   input  queue_status_type qstat,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output result_type       out_result
);

   typedef struct packed {
      logic [STATE_BITS-1:0] value;
      logic [PEAK_BITS-1:0]  mag;
      logic                  clipped;
   } round_sat_type;

   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [RND_BITS-1:0] LIMIT =
      {{(RND_BITS-PEAK_BITS){1'b0}}, {PEAK_BITS{1'b1}}};

   // six partial products and the rounding half into one sum
   function automatic logic signed [ACC_BITS-1:0] sum_terms(
      input logic signed [HI_PROD_BITS-1:0] hd,
      input logic signed [LO_PROD_BITS-1:0] ld,
      input logic signed [HI_PROD_BITS-1:0] hv,
      input logic signed [LO_PROD_BITS-1:0] lv,
      input logic signed [F_PROD_BITS-1:0]  fp,
      input logic signed [F_PROD_BITS-1:0]  fn
   );
      return (ACC_BITS'(hd) <<< LO_BITS) + ACC_BITS'(ld)
           + (ACC_BITS'(hv) <<< LO_BITS) + ACC_BITS'(lv)
           + ACC_BITS'(fp) + ACC_BITS'(fn) + ROUND_HALF;
   endfunction

   // drop fraction bits, clamp to the symmetric state range
   function automatic round_sat_type round_sat(input logic signed [ACC_BITS-1:0] acc);
      logic signed [RND_BITS-1:0] r;
      logic signed [RND_BITS-1:0] ar;
      logic signed [RND_BITS-1:0] neg_limit;
      round_sat_type              res;
      r         = acc[ACC_BITS-1:COEF_FRAC_BITS];
      ar        = r[RND_BITS-1] ? -r : r;
      neg_limit = -LIMIT;
      res.clipped = 1'b0;
      if (r > LIMIT) begin
         res.value   = LIMIT[STATE_BITS-1:0];
         res.clipped = 1'b1;
      end else if (r < neg_limit) begin
         res.value   = neg_limit[STATE_BITS-1:0];
         res.clipped = 1'b1;
      end else begin
         res.value = r[STATE_BITS-1:0];
      end
      res.mag = (ar > LIMIT) ? LIMIT[PEAK_BITS-1:0] : ar[PEAK_BITS-1:0];
      return res;
   endfunction

   engine_state_type state_ff;
   engine_state_type state_in;

   logic signed [STATE_BITS-1:0]  disp_ff;
   logic signed [STATE_BITS-1:0]  vel_ff;
   logic signed [SAMPLE_BITS-1:0] prev_ff;
   logic [PEAK_BITS-1:0]          peak_ff;
   logic [PEAK_BITS-1:0]          mag_ff;
   logic                          mag_pend_ff;
   logic                          sat_ff;
   logic                          last_ff;
   logic                          out_valid_ff;
   result_type                    out_result_ff;

   logic signed [HI_PROD_BITS-1:0] pdd_hi_ff, pdv_hi_ff, pvd_hi_ff, pvv_hi_ff;
   logic signed [LO_PROD_BITS-1:0] pdd_lo_ff, pdv_lo_ff, pvd_lo_ff, pvv_lo_ff;
   logic signed [F_PROD_BITS-1:0]  pdp_ff, pdn_ff, pvp_ff, pvn_ff;
   logic signed [ACC_BITS-1:0]     acc_d_ff, acc_v_ff;

   logic signed [HI_BITS-1:0]     disp_hi, vel_hi;
   logic signed [LO_BITS:0]       disp_lo, vel_lo;
   logic signed [SAMPLE_BITS-1:0] new_sample;
   round_sat_type                 new_d, new_v;
   logic [PEAK_BITS-1:0]          fold_peak;
   logic                          out_free;
   logic                          issue;
   logic                          prime;
   logic                          emit;

   assign disp_hi    = disp_ff[STATE_BITS-1:LO_BITS];
   assign vel_hi     = vel_ff[STATE_BITS-1:LO_BITS];
   assign disp_lo    = $signed({1'b0, disp_ff[LO_BITS-1:0]});
   assign vel_lo     = $signed({1'b0, vel_ff[LO_BITS-1:0]});
   assign new_sample = $signed(head.sample);
   assign new_d      = round_sat(acc_d_ff);
   assign new_v      = round_sat(acc_v_ff);
   assign out_free   = !out_valid_ff || out_ready;
   assign fold_peak  = (mag_pend_ff && (mag_ff > peak_ff)) ? mag_ff : peak_ff;
   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (qstat.not_empty && head.kind == KIND_UPDATE) begin
               state_in = ENG_SUM;
            end
         end
         ENG_SUM: state_in = ENG_SAT;
         ENG_SAT: state_in = last_ff ? ENG_FIN : ENG_IDLE;
         ENG_FIN: begin
            if (out_free) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      issue = 1'b0;
      prime = 1'b0;
      emit  = 1'b0;
      unique case (state_ff)
         ENG_IDLE: begin
            if (qstat.not_empty) begin
               if (head.kind == KIND_UPDATE) begin
                  issue = 1'b1;
               end else if (!head.last) begin
                  prime = 1'b1;
               end else if (out_free) begin
                  prime = 1'b1;
                  emit  = 1'b1;
               end
            end
         end
         ENG_FIN: emit = out_free;
         default: begin
         end
      endcase
      pop = issue || prime;
   end

   // partial products, captured when an update issues
   always_ff @(posedge clock) begin
      if (issue) begin
         pdd_hi_ff <= $signed(coefs.disp_from_disp) * disp_hi;
         pdd_lo_ff <= $signed(coefs.disp_from_disp) * disp_lo;
         pdv_hi_ff <= $signed(coefs.disp_from_vel) * vel_hi;
         pdv_lo_ff <= $signed(coefs.disp_from_vel) * vel_lo;
         pdp_ff    <= $signed(coefs.disp_from_prev_force) * prev_ff;
         pdn_ff    <= $signed(coefs.disp_from_new_force) * new_sample;
         pvd_hi_ff <= $signed(coefs.vel_from_disp) * disp_hi;
         pvd_lo_ff <= $signed(coefs.vel_from_disp) * disp_lo;
         pvv_hi_ff <= $signed(coefs.vel_from_vel) * vel_hi;
         pvv_lo_ff <= $signed(coefs.vel_from_vel) * vel_lo;
         pvp_ff    <= $signed(coefs.vel_from_prev_force) * prev_ff;
         pvn_ff    <= $signed(coefs.vel_from_new_force) * new_sample;
         last_ff   <= head.last;
      end
   end

   // accumulation of partial products
   always_ff @(posedge clock) begin
      acc_d_ff <= sum_terms(pdd_hi_ff, pdd_lo_ff, pdv_hi_ff, pdv_lo_ff, pdp_ff, pdn_ff);
      acc_v_ff <= sum_terms(pvd_hi_ff, pvd_lo_ff, pvv_hi_ff, pvv_lo_ff, pvp_ff, pvn_ff);
   end

   // magnitude of the newest displacement
   always_ff @(posedge clock) begin
      if (state_ff == ENG_SAT) begin
         mag_ff <= new_d.mag;
      end
   end

   // oscillator and record state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ENG_IDLE;
         disp_ff     <= '0;
         vel_ff      <= '0;
         prev_ff     <= '0;
         peak_ff     <= '0;
         mag_pend_ff <= 1'b0;
         sat_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            // end of record clears everything
            disp_ff     <= '0;
            vel_ff      <= '0;
            prev_ff     <= '0;
            peak_ff     <= '0;
            mag_pend_ff <= 1'b0;
            sat_ff      <= 1'b0;
         end else begin
            if (pop) begin
               prev_ff <= new_sample;
            end
            if (state_ff == ENG_SAT) begin
               disp_ff     <= $signed(new_d.value);
               vel_ff      <= $signed(new_v.value);
               mag_pend_ff <= 1'b1;
               sat_ff      <= sat_ff || new_d.clipped || new_v.clipped;
            end else if (mag_pend_ff) begin
               peak_ff     <= fold_peak;
               mag_pend_ff <= 1'b0;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_result_ff.peak       <= fold_peak;
         out_result_ff.overflowed <= sat_ff;
      end
   end

endmodule

### rtl/core/sdofp_checker.sv
// ----------------------------------------------------------------------------
// sdofp_checker
// Port-level checks of the oscillator peak block, bound to the top level.
// ----------------------------------------------------------------------------
module sdofp_checker
   import sdofp_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [REQ_DATA_BITS-1:0] req_tdata,
   input logic                     req_tlast,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tuser,
   input logic                     csr_psel,
   input logic                     csr_penable,
   input logic                     csr_pwrite,
   input logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [CSR_DATA_BITS-1:0] csr_prdata,
   input logic                     csr_pready
);

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // a stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result transaction changed while stalled");

   // leaving reset: no result pending and the queue takes samples
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // a register reads back what was just written to it
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      $past(csr_wr) && !$past(reset) && csr_psel && !csr_pwrite &&
      csr_paddr == $past(csr_paddr) |-> csr_prdata == $past(csr_pwdata))
      else $error("register read-back mismatch");

endmodule

bind sdof_response_spectrum_peak sdofp_checker u_sdofp_checker (.*);

### bench/sdofp_peak_checker.sv
// ----------------------------------------------------------------------------
// sdofp_peak_checker
// Watches the sample, result and register ports of the oscillator peak
// block, runs its own fixed-point oscillator on every accepted sample and
// compares each result transaction against the oldest predicted peak.
// ----------------------------------------------------------------------------
module sdofp_peak_checker
   import sdofp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [23:0] sample
   input  logic                     req_tlast,   // last_sample
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [46:0] peak_displacement, [47] zero
   input  logic                     rsp_tuser,   // [0] overflowed
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                     csr_pready,
   output int                       fail_count,
   output int                       results_pending
);

   localparam logic signed [127:0] STATE_LIMIT = (128'sd1 <<< (STATE_BITS - 1)) - 128'sd1;
   localparam logic signed [127:0] ROUND_HALF  = 128'sd1 <<< (COEF_FRAC_BITS - 1);

   // shadow of the coefficient registers and of the oscillator
   logic signed [COEF_BITS-1:0]   coef [NUM_COEFS];
   logic signed [STATE_BITS-1:0]  disp, vel, next_disp, next_vel;
   logic signed [SAMPLE_BITS-1:0] prev_sample, new_sample;
   logic        [STATE_BITS-1:0]  disp_mag;
   logic        [PEAK_BITS-1:0]   peak_abs;
   logic                          primed, saturated, disp_clip, vel_clip;

   result_type peak_queue [$];
   result_type seen, want;
   int         mismatches = 0;

   // one weighted sum, rounded half up and clamped to the symmetric range
   function automatic logic signed [STATE_BITS-1:0] integrate_step(
      input  logic signed [COEF_BITS-1:0]   w_disp, w_vel, w_prev, w_new,
      input  logic signed [STATE_BITS-1:0]  d, v,
      input  logic signed [SAMPLE_BITS-1:0] p, n,
      output logic                          clip
   );
      logic signed [127:0] acc;
      acc  = w_disp * d + w_vel * v + w_prev * p + w_new * n + ROUND_HALF;
      acc  = acc >>> COEF_FRAC_BITS;
      clip = (acc > STATE_LIMIT) || (acc < -STATE_LIMIT);
      if (acc > STATE_LIMIT)
         acc = STATE_LIMIT;
      else if (acc < -STATE_LIMIT)
         acc = -STATE_LIMIT;
      return acc[STATE_BITS-1:0];
   endfunction

   task automatic clear_record();
      disp        = '0;
      vel         = '0;
      prev_sample = '0;
      peak_abs    = '0;
      primed      = 1'b0;
      saturated   = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] wanted);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, wanted);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (coef[i]) coef[i] = '0;
         clear_record();
         peak_queue.delete();
      end else begin
         // register write transaction
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            coef[csr_paddr[CSR_ADDR_BITS-1:2]] = csr_pwdata;

         // result transaction against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen.peak       = rsp_tdata[PEAK_BITS-1:0];
            seen.overflowed = rsp_tuser;
            if (peak_queue.size() == 0) begin
               report_mismatch("unexpected result", seen.peak, '0);
            end else begin
               want = peak_queue.pop_front();
               if (seen.peak != want.peak)
                  report_mismatch("peak_displacement", seen.peak, want.peak);
               if (seen.overflowed != want.overflowed)
                  report_mismatch("overflowed", seen.overflowed, want.overflowed);
            end
         end

         // sample transaction: first of a record only primes
         if (req_tvalid && req_tready) begin
            new_sample = req_tdata[SAMPLE_BITS-1:0];
            if (!primed) begin
               primed = 1'b1;
            end else begin
               next_disp = integrate_step(coef[REG_DISP_FROM_DISP], coef[REG_DISP_FROM_VEL],
                                          coef[REG_DISP_FROM_PREV_FORCE],
                                          coef[REG_DISP_FROM_NEW_FORCE],
                                          disp, vel, prev_sample, new_sample, disp_clip);
               next_vel  = integrate_step(coef[REG_VEL_FROM_DISP], coef[REG_VEL_FROM_VEL],
                                          coef[REG_VEL_FROM_PREV_FORCE],
                                          coef[REG_VEL_FROM_NEW_FORCE],
                                          disp, vel, prev_sample, new_sample, vel_clip);
               disp_mag  = next_disp[STATE_BITS-1] ? -next_disp : next_disp;
               if (disp_mag[PEAK_BITS-1:0] > peak_abs)
                  peak_abs = disp_mag[PEAK_BITS-1:0];
               saturated = saturated | disp_clip | vel_clip;
               disp      = next_disp;
               vel       = next_vel;
            end
            prev_sample = new_sample;
            // end of record: queue the peak, then start over
            if (req_tlast) begin
               want.peak       = peak_abs;
               want.overflowed = saturated;
               peak_queue.push_back(want);
               clear_record();
            end
         end
      end
      results_pending <= peak_queue.size();
      fail_count      <= mismatches;
   end

endmodule

### bench/tb_sdof_response_spectrum_peak.sv
// ----------------------------------------------------------------------------
// tb_sdof_response_spectrum_peak
// Drives excitation records into the oscillator peak block under several
// coefficient sets (damped, stable random, full random, limit values) with
// bursty input and a stalling result side; the checker predicts each peak.
// ----------------------------------------------------------------------------
module tb_sdof_response_spectrum_peak;
   import sdofp_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_ITEMS   = 240;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum int {COEF_DAMPED, COEF_STABLE, COEF_RANDOM, COEF_CORNER} coef_style_type;
   typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MOSTLY} ready_style_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // [23:0] sample
   logic                     req_tlast;   // last_sample
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // [46:0] peak_displacement, [47] zero
   logic                     rsp_tuser;   // [0] overflowed
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int fail_count;
   int results_pending;
   int burst_left   = 0;
   int hold_left    = 0;
   int quiet_cycles = 0;

   sdof_response_spectrum_peak DUT (.*);

   sdofp_peak_checker peak_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // coefficient sets for one run of records
   function automatic coef_set_type make_coefs(input coef_style_type style);
      coef_set_type                   cs;
      logic [NUM_COEFS*COEF_BITS-1:0] flat;
      case (style)
         COEF_DAMPED: begin
            // lightly damped, eigenvalues near 0.97
            cs.disp_from_disp       = 32'h3CCC_CCCD;
            cs.disp_from_vel        = 32'h1333_3333;
            cs.disp_from_prev_force = 32'h0147_AE14;
            cs.disp_from_new_force  = 32'h00A3_D70A;
            cs.vel_from_disp        = 32'hECCC_CCCD;
            cs.vel_from_vel         = 32'h3999_999A;
            cs.vel_from_prev_force  = 32'hFCCC_CCCD;
            cs.vel_from_new_force   = 32'h0333_3333;
         end
         COEF_STABLE: begin
            // diagonal 0.5..0.75, cross terms within 1/8, forcing within 1
            cs.disp_from_disp       = 32'h2000_0000 + ($urandom() & 32'h0FFF_FFFF);
            cs.vel_from_vel         = 32'h2000_0000 + ($urandom() & 32'h0FFF_FFFF);
            cs.disp_from_vel        = ($urandom() & 32'h0FFF_FFFF) - 32'h0800_0000;
            cs.vel_from_disp        = ($urandom() & 32'h0FFF_FFFF) - 32'h0800_0000;
            cs.disp_from_prev_force = ($urandom() & 32'h7FFF_FFFF) - 32'h4000_0000;
            cs.disp_from_new_force  = ($urandom() & 32'h7FFF_FFFF) - 32'h4000_0000;
            cs.vel_from_prev_force  = ($urandom() & 32'h7FFF_FFFF) - 32'h4000_0000;
            cs.vel_from_new_force   = ($urandom() & 32'h7FFF_FFFF) - 32'h4000_0000;
         end
         default: begin
            for (int i = 0; i < NUM_COEFS; i++) begin
               if (style == COEF_RANDOM)
                  flat[i*COEF_BITS +: COEF_BITS] = $urandom();
               else
                  case ($urandom_range(0, 3))
                     0:       flat[i*COEF_BITS +: COEF_BITS] = 32'h7FFF_FFFF;
                     1:       flat[i*COEF_BITS +: COEF_BITS] = 32'h8000_0000;
                     2:       flat[i*COEF_BITS +: COEF_BITS] = 32'h0000_0000;
                     default: flat[i*COEF_BITS +: COEF_BITS] = 32'hFFFF_FFFF;
                  endcase
            end
            cs = flat;
         end
      endcase
      return cs;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] rand_sample();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return {{(SAMPLE_BITS-9){r[8]}}, r[8:0]};
         default: return r[SAMPLE_BITS-1:0];
      endcase
   endfunction

   function automatic int record_length(input bit short_only);
      if (short_only)
         return $urandom_range(1, 3);
      case ($urandom_range(0, 19))
         0:          return 1;
         1, 2, 3, 4: return $urandom_range(13, 40);
         default:    return $urandom_range(2, 12);
      endcase
   endfunction

   // apb write; psel stays up so writes can follow back to back
   task automatic write_coef(input coef_index_type which, input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic load_coefs(input coef_set_type cs);
      write_coef(REG_DISP_FROM_DISP,       cs.disp_from_disp);
      write_coef(REG_DISP_FROM_VEL,        cs.disp_from_vel);
      write_coef(REG_DISP_FROM_PREV_FORCE, cs.disp_from_prev_force);
      write_coef(REG_DISP_FROM_NEW_FORCE,  cs.disp_from_new_force);
      write_coef(REG_VEL_FROM_DISP,        cs.vel_from_disp);
      write_coef(REG_VEL_FROM_VEL,         cs.vel_from_vel);
      write_coef(REG_VEL_FROM_PREV_FORCE,  cs.vel_from_prev_force);
      write_coef(REG_VEL_FROM_NEW_FORCE,   cs.vel_from_new_force);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // one sample transaction, with a random gap at the start of each burst
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(value);
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_record(input int len);
      for (int k = 1; k <= len; k++)
         send_sample(rand_sample(), k == len);
   endtask

   // pause the sender until every predicted peak has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input coef_style_type style, input bit pressure);
      int sent;
      int len;
      load_coefs(make_coefs(style));
      if (pressure)
         hold_left = HOLD_CYCLES;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         len = record_length(pressure);
         send_record(len);
         sent += len;
         if ($urandom_range(0, 15) == 0)
            wait_drained();
      end
      wait_drained();
   endtask

   // result side: random ready segments, plus a long hold-off on request
   initial begin
      int              seg_left;
      ready_style_type seg_style;
      rsp_tready = 1'b0;
      seg_left   = 0;
      seg_style  = READY_ALWAYS;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            if (seg_left == 0) begin
               seg_left  = $urandom_range(1, 64);
               seg_style = ready_style_type'($urandom_range(0, 3));
            end
            seg_left--;
            case (seg_style)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_HALF:   rsp_tready <= ($urandom_range(0, 1) == 0);
               READY_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
               default:      rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus and verdict
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-sample records at both extremes
      load_coefs(make_coefs(COEF_DAMPED));
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b1);
      // zero, extremes and unit steps in one record
      send_sample('0, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample('1, 1'b0);
      send_sample(SAMPLE_BITS'(1), 1'b1);
      // held negative limit, then a jump to the positive limit
      repeat (3) send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      wait_drained();

      // runaway response: every weight at its positive limit saturates
      load_coefs(coef_set_type'({NUM_COEFS{32'h7FFF_FFFF}}));
      for (int k = 1; k <= 14; k++)
         send_sample(SAMPLE_MAX, k == 14);
      wait_drained();

      // random records under changing coefficient sets
      run_phase(COEF_STABLE, 1'b0);
      run_phase(COEF_RANDOM, 1'b0);
      run_phase(COEF_DAMPED, 1'b1);
      run_phase(COEF_CORNER, 1'b0);
      run_phase(COEF_STABLE, 1'b0);
      run_phase(COEF_CORNER, 1'b0);
      run_phase(COEF_RANDOM, 1'b0);

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/core/sdofp_pkg.sv
rtl/core/sdofp_csr.sv
rtl/core/sdofp_front.sv
rtl/core/sdofp_queue.sv
rtl/core/sdofp_engine.sv
rtl/core/sdof_response_spectrum_peak.sv
rtl/core/sdofp_checker.sv
bench/sdofp_peak_checker.sv
bench/tb_sdof_response_spectrum_peak.sv
